/* rtl/core/rgbhsl_pkg.sv */
// Shared widths, constants and the stage record of the RGB to HSL converter.
// Depends on nothing; every other file of the block imports it.
package rgbhsl_pkg;
  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS = 15;
  localparam int SAT_BITS = 16;
  localparam int LIGHT_BITS = CHANNEL_BITS + 1;
  // Quotient bits per division: saturation reaches exactly 1.0, one bit more.
  localparam int QUOT_BITS = SAT_BITS + 1;
  localparam int REM_BITS = CHANNEL_BITS + QUOT_BITS;
  localparam int NUM_CELLS = QUOT_BITS;
  localparam logic [REM_BITS-1:0] SECTOR_UNITS = REM_BITS'(3840);
  localparam logic [REM_BITS-1:0] FULL_TURN = REM_BITS'(23040);
  localparam logic [LIGHT_BITS-1:0] TWO_FULL =
    LIGHT_BITS'((2 ** CHANNEL_BITS - 1) * 2);
  localparam logic [SAT_BITS-1:0] SAT_MAX = '1;

  typedef struct packed {
    logic                    valid;
    logic                    gray;
    logic [REM_BITS-1:0]     hue_rem;
    logic [REM_BITS-1:0]     hue_div;
    logic [QUOT_BITS-1:0]    hue_quot;
    logic [REM_BITS-1:0]     sat_rem;
    logic [REM_BITS-1:0]     sat_div;
    logic [QUOT_BITS-1:0]    sat_quot;
    logic [LIGHT_BITS-1:0]   light;
    logic [CHANNEL_BITS-1:0] alpha;
  } stage_t;
endpackage

/* rtl/core/rgbhsl_front.sv */
// Front stage: max, min, delta, lightness and the two division operands.
// Depends on rgbhsl_pkg.
module rgbhsl_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [rgbhsl_pkg::CHANNEL_BITS-1:0] red,
  input  logic [rgbhsl_pkg::CHANNEL_BITS-1:0] green,
  input  logic [rgbhsl_pkg::CHANNEL_BITS-1:0] blue,
  input  logic [rgbhsl_pkg::CHANNEL_BITS-1:0] alpha,
  output rgbhsl_pkg::stage_t               stage
);
  import rgbhsl_pkg::*;

  logic [CHANNEL_BITS-1:0] hi, lo, delta, den;
  logic [LIGHT_BITS-1:0]   light, light_inv;
  logic [REM_BITS-1:0]     r_w, g_w, b_w, d_w, x;

  always_comb begin
    hi = red;
    lo = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    delta = hi - lo;
    light = LIGHT_BITS'(hi) + LIGHT_BITS'(lo);
    light_inv = TWO_FULL - light;
    den = (light < light_inv) ? light[CHANNEL_BITS-1:0] : light_inv[CHANNEL_BITS-1:0];
    r_w = REM_BITS'(red);
    g_w = REM_BITS'(green);
    b_w = REM_BITS'(blue);
    d_w = REM_BITS'(delta);
    // Hue times delta, kept non-negative; the red sector wraps by a full turn.
    if (hi == red) begin
      if (green >= blue) x = SECTOR_UNITS * (g_w - b_w);
      else x = FULL_TURN * d_w - SECTOR_UNITS * (b_w - g_w);
    end else if (hi == green) begin
      x = REM_BITS'(2) * SECTOR_UNITS * d_w + SECTOR_UNITS * b_w - SECTOR_UNITS * r_w;
    end else begin
      x = REM_BITS'(4) * SECTOR_UNITS * d_w + SECTOR_UNITS * r_w - SECTOR_UNITS * g_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= in_valid;
    end
    if (en) begin
      stage.gray     <= (delta == '0);
      stage.hue_rem  <= x;
      stage.hue_div  <= d_w << (QUOT_BITS - 1);
      stage.hue_quot <= '0;
      stage.sat_rem  <= d_w << SAT_BITS;
      stage.sat_div  <= REM_BITS'(den) << (QUOT_BITS - 1);
      stage.sat_quot <= '0;
      stage.light    <= light;
      stage.alpha    <= alpha;
    end
  end
endmodule

/* rtl/core/rgbhsl_cell.sv */
// One divider cell: a restoring step for hue and saturation, one quotient bit each.
// Depends on rgbhsl_pkg.
module rgbhsl_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  rgbhsl_pkg::stage_t prev,
  output rgbhsl_pkg::stage_t stage
);
  import rgbhsl_pkg::*;

  logic hue_ge, sat_ge;

  assign hue_ge = prev.hue_rem >= prev.hue_div;
  assign sat_ge = prev.sat_rem >= prev.sat_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= prev.valid;
    end
    if (en) begin
      stage.gray     <= prev.gray;
      stage.hue_rem  <= hue_ge ? prev.hue_rem - prev.hue_div : prev.hue_rem;
      stage.hue_div  <= prev.hue_div >> 1;
      stage.hue_quot <= {prev.hue_quot[QUOT_BITS-2:0], hue_ge};
      stage.sat_rem  <= sat_ge ? prev.sat_rem - prev.sat_div : prev.sat_rem;
      stage.sat_div  <= prev.sat_div >> 1;
      stage.sat_quot <= {prev.sat_quot[QUOT_BITS-2:0], sat_ge};
      stage.light    <= prev.light;
      stage.alpha    <= prev.alpha;
    end
  end
endmodule

/* rtl/core/rgb_to_hsl_converter.sv */
// Top level of the RGB to HSL converter: front stage and a chain of divider cells.
// Depends on rgbhsl_pkg, rgbhsl_front and rgbhsl_cell.
//
//   channel | handshake                  | fields
//   input   | in_valid, in_stall (out)   | red, green, blue, alpha
//   output  | out_valid, out_stall (in)  | hue, saturation, lightness, opacity
//
// One item enters per cycle while in_stall is low. Each item passes one front stage
// and one cell per quotient bit of the two shared-step dividers.
// Reset clears only the valid bits of the stages.
// A stage moves when it is empty or the stage after it moves, so bubbles are
// squeezed out while the output is stalled; in_stall rises only when every
// stage holds an item and the output item is not taken.
module rgb_to_hsl_converter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rgbhsl_pkg::CHANNEL_BITS-1:0]  red,
  input  logic [rgbhsl_pkg::CHANNEL_BITS-1:0]  green,
  input  logic [rgbhsl_pkg::CHANNEL_BITS-1:0]  blue,
  input  logic [rgbhsl_pkg::CHANNEL_BITS-1:0]  alpha,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rgbhsl_pkg::HUE_BITS-1:0]      hue,
  output logic [rgbhsl_pkg::SAT_BITS-1:0]      saturation,
  output logic [rgbhsl_pkg::LIGHT_BITS-1:0]    lightness,
  output logic [rgbhsl_pkg::CHANNEL_BITS-1:0]  opacity
);
  import rgbhsl_pkg::*;

  // Stage 0 is the front stage, stages 1..NUM_CELLS are the divider cells.
  stage_t             stages [NUM_CELLS+1];
  logic [NUM_CELLS+1:0] adv;
  stage_t             last;

  assign last = stages[NUM_CELLS];

  always_comb begin
    adv[NUM_CELLS+1] = ~(last.valid & out_stall);
    for (int i = NUM_CELLS; i >= 0; i--) begin
      adv[i] = ~stages[i].valid | adv[i+1];
    end
  end

  assign in_stall = ~adv[0];

  rgbhsl_front u_front (
    .clk(clk), .rst(rst), .en(adv[0]), .in_valid(in_valid),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .stage(stages[0])
  );

  for (genvar i = 1; i <= NUM_CELLS; i++) begin : g_cell
    rgbhsl_cell u_cell (
      .clk(clk), .rst(rst), .en(adv[i]),
      .prev(stages[i-1]), .stage(stages[i])
    );
  end

  // Gray pixels skip both quotients; a saturation of exactly 1.0 clips.
  assign out_valid  = last.valid;
  assign hue        = last.gray ? '0 : last.hue_quot[HUE_BITS-1:0];
  assign saturation = last.gray ? '0 :
                      (last.sat_quot[QUOT_BITS-1] ? SAT_MAX : last.sat_quot[SAT_BITS-1:0]);
  assign lightness  = last.light;
  assign opacity    = last.alpha;

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue < HUE_BITS'(23040)))
    else $error("hue out of range");

  a_sat_color: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last.gray) |-> (saturation != '0))
    else $error("colored pixel with zero saturation");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && stages[0].valid))
    else $error("input stalled with room in the chain");
endmodule
